// ===== design/ssmc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssmc_pkg: shared types and constants of the servo sweep mode controller
// Field widths, register reset values, register indexes and the beat
// structures passed between the input stage and the update stage.
// ---------------------------------------------------------------------------
package ssmc_pkg;

    localparam int MAX_ANGLE_DEF = 180;
    localparam int POT_BITS_DEF  = 12;

    localparam int ANGLE_W     = 8;
    localparam int TEMP_W      = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int OUT_TDATA_W = 24;

    // register reset values
    localparam logic [7:0]               STEP_INTERVAL_RST  = 8'd20;
    localparam logic [7:0]               DEBOUNCE_TIME_RST  = 8'd50;
    localparam logic [9:0]               BUZZER_TIME_RST    = 10'd300;
    localparam logic [3:0]               STEP_SIZE_RST      = 4'd2;
    localparam logic signed [TEMP_W-1:0] TEMP_THRESHOLD_RST = 11'sd250;

    // saturation limits of the elapsed counters
    localparam logic [7:0] STEP_EL_MAX   = 8'd255;
    localparam logic [8:0] CHANGE_EL_MAX = 9'd511;
    localparam logic [9:0] BUZZER_EL_MAX = 10'd1023;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STEP_INTERVAL  = 3'd0,
        CFG_DEBOUNCE_TIME  = 3'd1,
        CFG_BUZZER_TIME    = 3'd2,
        CFG_STEP_SIZE      = 3'd3,
        CFG_TEMP_THRESHOLD = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]               step_interval;
        logic [7:0]               debounce_time;
        logic [9:0]               buzzer_time;
        logic [3:0]               step_size;
        logic signed [TEMP_W-1:0] temp_threshold;
    } t_cfg;

    // one tick after the input register, pot already mapped to degrees
    typedef struct packed {
        logic                     button_level;
        logic [ANGLE_W-1:0]       pot_angle;
        logic                     temp_valid;
        logic signed [TEMP_W-1:0] temperature;
    } t_tick;

    typedef struct packed {
        logic [ANGLE_W-1:0] cmd_angle;
        logic [ANGLE_W-1:0] target_angle;
        logic               buzzer_on;
        logic               temp_sweep;
        logic               sweep_active;
    } t_result;

endpackage

// ===== design/ssmc_pot_map.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssmc_pot_map: potentiometer sample to angle
// Computes pot * MAX_ANGLE / (2^POT_BITS - 1), truncated, with a reciprocal
// estimate and one remainder correction.
// ---------------------------------------------------------------------------
module ssmc_pot_map #(
    parameter int POT_BITS  = ssmc_pkg::POT_BITS_DEF,
    parameter int MAX_ANGLE = ssmc_pkg::MAX_ANGLE_DEF
) (
    input  logic [POT_BITS-1:0]         i_pot,
    output logic [ssmc_pkg::ANGLE_W-1:0] o_angle
);
    import ssmc_pkg::*;

    localparam int XW = POT_BITS + ANGLE_W;
    localparam logic [XW-1:0] MAX_X   = XW'(MAX_ANGLE);
    localparam logic [XW:0]   DIVISOR = (XW+1)'((1 << POT_BITS) - 1);
    localparam logic [ANGLE_W:0] MAX_Q = (ANGLE_W+1)'(MAX_ANGLE);

    logic [XW-1:0]    x;
    logic [XW:0]      sum;
    logic [ANGLE_W:0] q_est;
    logic [ANGLE_W:0] q_fix;
    logic [XW:0]      rem;

    // estimate never exceeds the true quotient and falls short by one at most
    always_comb begin
        x     = XW'(i_pot) * MAX_X;
        sum   = {1'b0, x} + (XW+1)'(x >> POT_BITS);
        q_est = (ANGLE_W+1)'(sum >> POT_BITS);
        rem   = {1'b0, x} - (((XW+1)'(q_est) << POT_BITS) - (XW+1)'(q_est));
        q_fix = (rem >= DIVISOR) ? q_est + 1'b1 : q_est;
        o_angle = (q_fix > MAX_Q) ? MAX_Q[ANGLE_W-1:0] : q_fix[ANGLE_W-1:0];
    end

endmodule

// ===== design/ssmc_in_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssmc_in_stage: input register
// Captures an accepted tick with the pot sample mapped to degrees and holds
// it until the update stage takes it.
// ---------------------------------------------------------------------------
module ssmc_in_stage #(
    parameter int POT_BITS  = ssmc_pkg::POT_BITS_DEF,
    parameter int MAX_ANGLE = ssmc_pkg::MAX_ANGLE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic                               i_advance,
    input  logic                               i_button_level,
    input  logic [POT_BITS-1:0]                i_pot_sample,
    input  logic                               i_temp_valid,
    input  logic signed [ssmc_pkg::TEMP_W-1:0] i_temperature_tenths,
    output logic                               o_valid,
    output ssmc_pkg::t_tick                    o_item
);
    import ssmc_pkg::*;

    logic               r_valid;
    logic               n_valid;
    t_tick              r_item;
    logic [ANGLE_W-1:0] pot_angle;

    ssmc_pot_map #(
        .POT_BITS  (POT_BITS),
        .MAX_ANGLE (MAX_ANGLE)
    ) u_pot_map (
        .i_pot   (i_pot_sample),
        .o_angle (pot_angle)
    );

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.button_level <= i_button_level;
            r_item.pot_angle    <= pot_angle;
            r_item.temp_valid   <= i_temp_valid;
            r_item.temperature  <= i_temperature_tenths;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/ssmc_update.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssmc_update: per-tick state update and result register
// Applies temperature, debounce, buzzer timeout and servo motion for one
// tick; the updated state registers are the result beat.
// ---------------------------------------------------------------------------
module ssmc_update #(
    parameter int MAX_ANGLE = ssmc_pkg::MAX_ANGLE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_out_ready,
    input  ssmc_pkg::t_tick   i_item,
    input  ssmc_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output ssmc_pkg::t_result o_result
);
    import ssmc_pkg::*;

    localparam logic [ANGLE_W-1:0]        MAX_A = ANGLE_W'(MAX_ANGLE);
    localparam logic signed [ANGLE_W+1:0] MAX_S = (ANGLE_W+2)'(MAX_ANGLE);

    logic               r_valid,     n_valid;
    logic [ANGLE_W-1:0] r_angle,     n_angle;
    logic [ANGLE_W-1:0] r_held,      n_held;
    logic               r_dir_down,  n_dir_down;
    logic               r_auto,      n_auto;
    logic               r_sweep,     n_sweep;
    logic [7:0]         r_step_el,   n_step_el;
    logic               r_raw_prev,  n_raw_prev;
    logic               r_stable,    n_stable;
    logic [8:0]         r_change_el, n_change_el;
    logic               r_buzzer,    n_buzzer;
    logic [9:0]         r_buzzer_el, n_buzzer_el;

    logic [8:0]                ce;
    logic [9:0]                be;
    logic [7:0]                se;
    logic signed [ANGLE_W+1:0] next_pos;
    logic signed [ANGLE_W+1:0] delta;

    always_comb begin
        n_valid     = r_valid;
        n_angle     = r_angle;
        n_held      = r_held;
        n_dir_down  = r_dir_down;
        n_auto      = r_auto;
        n_sweep     = r_sweep;
        n_step_el   = r_step_el;
        n_raw_prev  = r_raw_prev;
        n_stable    = r_stable;
        n_change_el = r_change_el;
        n_buzzer    = r_buzzer;
        n_buzzer_el = r_buzzer_el;
        ce          = r_change_el;
        be          = r_buzzer_el;
        se          = r_step_el;
        delta       = '0;
        next_pos    = '0;

        if (i_advance) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end

        if (i_advance) begin
            if (i_item.temp_valid) begin
                n_auto = (i_item.temperature > i_cfg.temp_threshold);
            end

            // debounce: restart the quiet count on any level change
            ce = (i_item.button_level != r_raw_prev) ? '0 : r_change_el;
            if ((ce > {1'b0, i_cfg.debounce_time}) && (i_item.button_level != r_stable)) begin
                n_stable = i_item.button_level;
                if (!i_item.button_level && !n_auto && !r_sweep) begin
                    n_held     = i_item.pot_angle;
                    n_sweep    = 1'b1;
                    n_dir_down = 1'b0;
                    n_buzzer   = 1'b1;
                    be         = '0;
                    n_angle    = '0;
                end
            end
            n_raw_prev  = i_item.button_level;
            n_change_el = (ce == CHANGE_EL_MAX) ? ce : ce + 1'b1;

            if (n_buzzer && (be >= i_cfg.buzzer_time)) begin
                n_buzzer = 1'b0;
            end
            n_buzzer_el = (be == BUZZER_EL_MAX) ? be : be + 1'b1;

            if (n_auto || n_sweep) begin
                if (se >= i_cfg.step_interval) begin
                    se       = '0;
                    delta    = (ANGLE_W+2)'(i_cfg.step_size);
                    next_pos = n_dir_down ? $signed({2'b00, n_angle}) - delta
                                          : $signed({2'b00, n_angle}) + delta;
                    if (n_auto) begin
                        if (next_pos >= MAX_S) begin
                            n_angle    = MAX_A;
                            n_dir_down = 1'b1;
                        end else if (next_pos <= 0) begin
                            n_angle    = '0;
                            n_dir_down = 1'b0;
                        end else begin
                            n_angle = next_pos[ANGLE_W-1:0];
                        end
                    end else if (next_pos >= MAX_S) begin
                        n_angle    = MAX_A;
                        n_dir_down = 1'b1;
                    end else if ((next_pos <= 0) && n_dir_down) begin
                        // sweep done: return to the angle captured at the press
                        n_sweep = 1'b0;
                        n_angle = n_held;
                    end else if (next_pos <= 0) begin
                        n_angle = '0;
                    end else begin
                        n_angle = next_pos[ANGLE_W-1:0];
                    end
                end
            end else begin
                n_held  = i_item.pot_angle;
                n_angle = i_item.pot_angle;
            end
            n_step_el = (se == STEP_EL_MAX) ? se : se + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_angle     <= '0;
            r_held      <= '0;
            r_dir_down  <= 1'b0;
            r_auto      <= 1'b0;
            r_sweep     <= 1'b0;
            r_step_el   <= STEP_EL_MAX;
            r_raw_prev  <= 1'b1;
            r_stable    <= 1'b1;
            r_change_el <= '0;
            r_buzzer    <= 1'b0;
            r_buzzer_el <= '0;
        end else begin
            r_valid     <= n_valid;
            r_angle     <= n_angle;
            r_held      <= n_held;
            r_dir_down  <= n_dir_down;
            r_auto      <= n_auto;
            r_sweep     <= n_sweep;
            r_step_el   <= n_step_el;
            r_raw_prev  <= n_raw_prev;
            r_stable    <= n_stable;
            r_change_el <= n_change_el;
            r_buzzer    <= n_buzzer;
            r_buzzer_el <= n_buzzer_el;
        end
    end

    assign o_valid               = r_valid;
    assign o_result.cmd_angle    = r_angle;
    assign o_result.target_angle = r_held;
    assign o_result.buzzer_on    = r_buzzer;
    assign o_result.temp_sweep   = r_auto;
    assign o_result.sweep_active = r_sweep;

endmodule

// ===== design/servo_sweep_mode_controller_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// servo_sweep_mode_controller_core: servo sweep mode controller, top level
// One input beat per 1 ms tick: button level, pot sample, temperature.
// One result beat per tick: servo angle, pot target, buzzer, mode flags.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick per beat; m_axis returns exactly one result
//   beat per tick, in order. Registers are written on i_cfg_wr_en with
//   i_cfg_index selecting the register; write only while no tick is in
//   flight.
//   Path: an accepted tick sits in the input register and is folded into
//   the update/result register when the result slot is free, and its
//   result is then on m_axis.
//   Throughput: one tick per cycle while results are taken; the only loop
//   is the state update in the result stage, so ticks can follow every clock.
//   Stall: when m_axis_tready is low the result beat holds and the state
//   freezes; the input register still takes one more beat, then
//   s_axis_tready drops until the result is taken.
//   Reset: synchronous, active low; clears both stages, sets the state to
//   its idle values and loads the register defaults.
// ---------------------------------------------------------------------------
module servo_sweep_mode_controller_core #(
    parameter int MAX_ANGLE = ssmc_pkg::MAX_ANGLE_DEF,
    parameter int POT_BITS  = ssmc_pkg::POT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata from bit 0: button_level, pot_sample, temp_valid,
    // temperature_tenths, zero pad
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((POT_BITS+13+7)/8)*8-1:0]     s_axis_tdata,
    // tdata from bit 0: cmd_angle, target_angle, buzzer_on,
    // temp_sweep, sweep_active, zero pad
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ssmc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_wr_en,
    input  logic [ssmc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ssmc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import ssmc_pkg::*;

    localparam int TEMP_LSB = POT_BITS + 2;
    localparam int RES_W    = 2 * ANGLE_W + 3;

    t_cfg    r_cfg;
    t_tick   in_item;
    t_result result;
    logic    in_valid;
    logic    load;
    logic    advance;

    // hand the held tick to the update stage when the result slot frees up
    assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid || advance;
    assign load          = s_axis_tvalid && s_axis_tready;

    // register file: the user must write it only while idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_interval  <= STEP_INTERVAL_RST;
            r_cfg.debounce_time  <= DEBOUNCE_TIME_RST;
            r_cfg.buzzer_time    <= BUZZER_TIME_RST;
            r_cfg.step_size      <= STEP_SIZE_RST;
            r_cfg.temp_threshold <= TEMP_THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STEP_INTERVAL:  r_cfg.step_interval  <= i_cfg_wdata[7:0];
                CFG_DEBOUNCE_TIME:  r_cfg.debounce_time  <= i_cfg_wdata[7:0];
                CFG_BUZZER_TIME:    r_cfg.buzzer_time    <= i_cfg_wdata[9:0];
                CFG_STEP_SIZE:      r_cfg.step_size      <= i_cfg_wdata[3:0];
                CFG_TEMP_THRESHOLD: r_cfg.temp_threshold <= $signed(i_cfg_wdata[TEMP_W-1:0]);
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    ssmc_in_stage #(
        .POT_BITS  (POT_BITS),
        .MAX_ANGLE (MAX_ANGLE)
    ) u_in_stage (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_load               (load),
        .i_advance            (advance),
        .i_button_level       (s_axis_tdata[0]),
        .i_pot_sample         (s_axis_tdata[POT_BITS:1]),
        .i_temp_valid         (s_axis_tdata[POT_BITS+1]),
        .i_temperature_tenths ($signed(s_axis_tdata[TEMP_LSB+TEMP_W-1:TEMP_LSB])),
        .o_valid              (in_valid),
        .o_item               (in_item)
    );

    ssmc_update #(
        .MAX_ANGLE (MAX_ANGLE)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_out_ready (m_axis_tready),
        .i_item      (in_item),
        .i_cfg       (r_cfg),
        .o_valid     (m_axis_tvalid),
        .o_result    (result)
    );

    // pack the result beat, cmd_angle in the low byte
    assign m_axis_tdata = {
        (OUT_TDATA_W-RES_W)'(0),
        result.sweep_active,
        result.temp_sweep,
        result.buzzer_on,
        result.target_angle,
        result.cmd_angle
    };

endmodule

// ===== design/ssmc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssmc_checker: port-level checks of the servo sweep mode controller
// Watches the result channel for reset, hold, range and tracking rules.
// ---------------------------------------------------------------------------
module ssmc_checker #(
    parameter int MAX_ANGLE = ssmc_pkg::MAX_ANGLE_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ssmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ssmc_pkg::*;

    localparam logic [ANGLE_W-1:0] MAX_A = ANGLE_W'(MAX_ANGLE);

    logic [ANGLE_W-1:0] cmd_angle;
    logic [ANGLE_W-1:0] pot_target;
    logic               temp_sweep;
    logic               sweep_active;

    assign cmd_angle    = m_axis_tdata[ANGLE_W-1:0];
    assign pot_target   = m_axis_tdata[2*ANGLE_W-1:ANGLE_W];
    assign temp_sweep   = m_axis_tdata[2*ANGLE_W+1];
    assign sweep_active = m_axis_tdata[2*ANGLE_W+2];

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (cmd_angle <= MAX_A) && (pot_target <= MAX_A))
        else $error("angle above limit");

    a_idle_tracks_pot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !temp_sweep && !sweep_active |-> cmd_angle == pot_target)
        else $error("servo angle off pot target outside sweep");

endmodule

bind servo_sweep_mode_controller_core ssmc_checker #(
    .MAX_ANGLE (MAX_ANGLE)
) u_ssmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
